/* rtl/altimeter_flight_event_detector_macros.svh */
// Assertion macros for the flight event detector.
// Both expect clk and rst_n in the scope where they are used.
`ifndef ALTIMETER_FLIGHT_EVENT_DETECTOR_MACROS_SVH
`define ALTIMETER_FLIGHT_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AFED_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afed: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define AFED_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afed: next-cycle check failed");

`endif

/* rtl/afed_pkg.sv */
`default_nettype none

package afed_pkg;

  // fixed field widths
  localparam int ELAPSED_W  = 16;
  localparam int MODE_W     = 3;
  localparam int ALPHA_W    = 16;
  localparam int ALT_THR_W  = 24;
  localparam int SPD_THR_W  = 20;
  localparam int GND_THR_W  = 19;
  localparam int COUNT_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // shared multiplier: small operand is a weight or the ms-to-s scale
  localparam int MUL_A_W = ALPHA_W + 1;
  localparam int Q_FRAC  = 16;
  localparam logic signed [MUL_A_W-1:0] SPEED_SCALE = 17'sd1000;

  // event select codes
  localparam logic [MODE_W-1:0] MODE_LAUNCH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APOGEE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHUTE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GROUND = 3'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_ALT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_SPD  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LAUNCH_THR = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_APOGEE_THR = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CHUTE_ALT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUND_THR = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_MARGIN     = 3'd6;

  // register reset values
  localparam logic [ALPHA_W-1:0]          RST_ALPHA_ALT  = 16'd52429;
  localparam logic [ALPHA_W-1:0]          RST_ALPHA_SPD  = 16'd52429;
  localparam logic signed [ALT_THR_W-1:0] RST_LAUNCH_THR = 24'sd160;
  localparam logic signed [SPD_THR_W-1:0] RST_APOGEE_THR = -20'sd16;
  localparam logic signed [ALT_THR_W-1:0] RST_CHUTE_ALT  = 24'sd0;
  localparam logic [GND_THR_W-1:0]        RST_GROUND_THR = 19'd32;
  localparam logic [COUNT_W-1:0]          RST_MARGIN     = 8'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_ALT,
    ST_MUL_K,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SAT,
    ST_MUL_S,
    ST_SPD,
    ST_EVT
  } afed_state_t;

endpackage

`default_nettype wire

/* rtl/afed_in_if.sv */
`default_nettype none

interface afed_in_if #(parameter int AW = 24);
  import afed_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] altitude_sample;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [MODE_W-1:0]    mode;

  modport source (output valid, altitude_sample, elapsed_ms, mode, input ready);
  modport sink   (input valid, altitude_sample, elapsed_ms, mode, output ready);
endinterface

`default_nettype wire

/* rtl/afed_out_if.sv */
`default_nettype none

interface afed_out_if #(parameter int AW = 24, parameter int SW = 20);
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] filtered_altitude;
  logic signed [SW-1:0] filtered_speed;
  logic signed [AW-1:0] peak_altitude;
  logic signed [SW-1:0] peak_speed;
  logic                 event_fired;

  modport source (output valid, filtered_altitude, filtered_speed, peak_altitude,
                  peak_speed, event_fired, input ready);
  modport sink   (input valid, filtered_altitude, filtered_speed, peak_altitude,
                  peak_speed, event_fired, output ready);
endinterface

`default_nettype wire

/* rtl/afed_div.sv */
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module afed_div #(
  parameter int NW = 34
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [NW-1:0]                  dividend,
  input  logic [afed_pkg::ELAPSED_W-1:0] divisor,
  output logic [NW-1:0]                  quotient,
  output logic                           done
);
  import afed_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);

  logic [ELAPSED_W-1:0] rem_r, rem_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ELAPSED_W:0]   trial, diff;
  logic                 fits;

  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

/* rtl/altimeter_flight_event_detector.sv */
// The divider for vertical speed yields one quotient bit per cycle (ALTITUDE_BITS+10 bits).
// A finished result waits in the output register while the next word is accepted.
// Reset (rst_n, synchronous, active low) restores register defaults and clears the
// estimates, peaks and confirm counter.
`default_nettype none

module altimeter_flight_event_detector #(
  parameter int ALTITUDE_BITS = 24,
  parameter int SPEED_BITS    = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  afed_in_if.sink                         in_if,
  afed_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [afed_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [afed_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import afed_pkg::*;

  localparam int AW   = ALTITUDE_BITS;
  localparam int SW   = SPEED_BITS;
  // common width for differences fed to the multiplier
  localparam int DW   = ((AW > SW) ? AW : SW) + 1;
  localparam int PW   = DW + MUL_A_W;
  localparam int BW   = DW + 1;
  // |1000 * altitude step| < 2^(AW+10)
  localparam int NW   = AW + 10;
  localparam int QW   = ((NW > SW) ? NW : SW) + 1;
  localparam int WMAX = (AW > ALT_THR_W) ? AW : ALT_THR_W;
  // compare width: covers estimates and thresholds, signed
  localparam int CW   = ((WMAX > SW) ? WMAX : SW) + 1;

  localparam logic [PW-1:0] HALF_LSB    = PW'(32'd32768);
  localparam logic [QW-1:0] SPD_MAX_MAG = QW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [QW-1:0] SPD_MIN_MAG = QW'(64'd1 << (SW - 1));
  localparam logic [SW-1:0] SPD_MAX     = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SPD_MIN     = {1'b1, {(SW-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ALPHA_W-1:0]          alpha_alt_r;
  logic [ALPHA_W-1:0]          alpha_spd_r;
  logic signed [ALT_THR_W-1:0] launch_thr_r;
  logic signed [SPD_THR_W-1:0] apogee_thr_r;
  logic signed [ALT_THR_W-1:0] chute_alt_r;
  logic [GND_THR_W-1:0]        ground_thr_r;
  logic [COUNT_W-1:0]          margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_alt_r  <= RST_ALPHA_ALT;
      alpha_spd_r  <= RST_ALPHA_SPD;
      launch_thr_r <= RST_LAUNCH_THR;
      apogee_thr_r <= RST_APOGEE_THR;
      chute_alt_r  <= RST_CHUTE_ALT;
      ground_thr_r <= RST_GROUND_THR;
      margin_r     <= RST_MARGIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALPHA_ALT:  alpha_alt_r  <= cfg_wdata[ALPHA_W-1:0];
        REG_ALPHA_SPD:  alpha_spd_r  <= cfg_wdata[ALPHA_W-1:0];
        REG_LAUNCH_THR: launch_thr_r <= cfg_wdata[ALT_THR_W-1:0];
        REG_APOGEE_THR: apogee_thr_r <= cfg_wdata[SPD_THR_W-1:0];
        REG_CHUTE_ALT:  chute_alt_r  <= cfg_wdata[ALT_THR_W-1:0];
        REG_GROUND_THR: ground_thr_r <= cfg_wdata[GND_THR_W-1:0];
        REG_MARGIN:     margin_r     <= cfg_wdata[COUNT_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  afed_state_t state_r, state_nxt;
  logic        accept;
  logic        div_start;
  logic        evt_go;
  logic        div_done;
  logic        out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_if.valid) state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_ALT;
      ST_ALT:      state_nxt = ST_MUL_K;
      ST_MUL_K:    state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV:      if (div_done) state_nxt = ST_SAT;
      ST_SAT:      state_nxt = ST_MUL_S;
      ST_MUL_S:    state_nxt = ST_SPD;
      ST_SPD:      state_nxt = ST_EVT;
      ST_EVT:      if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    div_start   = 1'b0;
    evt_go      = 1'b0;
    case (state_r)
      ST_IDLE:     in_if.ready = 1'b1;
      ST_DIV_LOAD: div_start   = 1'b1;
      // commit only once the output register is free
      ST_EVT:      evt_go      = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  assign accept = in_if.ready && in_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------
  // Input word and filter state
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] x_r;
  logic [ELAPSED_W-1:0] t_r;
  logic [MODE_W-1:0]    mode_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_if.altitude_sample;
      // zero elapsed time counts as one ms
      t_r    <= (in_if.elapsed_ms == '0) ? ELAPSED_W'(1) : in_if.elapsed_ms;
      mode_r <= in_if.mode;
    end
  end

  logic signed [AW-1:0] alt_r, pk_alt_r, alt_new_r, alt_new_nxt, pk_alt_nxt;
  logic signed [SW-1:0] spd_r, pk_spd_r, spd_new_r, spd_new_nxt, pk_spd_nxt;
  logic signed [SW-1:0] raw_r, raw_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 neg_r;
  logic                 fire;

  // ---------------------------------------------------------------------------
  // Shared multiplier: altitude blend, x1000 scale, speed blend
  // ---------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [DW-1:0]      mul_b;
  logic signed [PW-1:0]      prod_nxt, prod_r;
  logic signed [DW-1:0]      alt_d, x_d, alt_new_d, spd_d, raw_d;

  assign alt_d     = $signed({{(DW-AW){alt_r[AW-1]}}, alt_r});
  assign x_d       = $signed({{(DW-AW){x_r[AW-1]}}, x_r});
  assign alt_new_d = $signed({{(DW-AW){alt_new_r[AW-1]}}, alt_new_r});
  assign spd_d     = $signed({{(DW-SW){spd_r[SW-1]}}, spd_r});
  assign raw_d     = $signed({{(DW-SW){raw_r[SW-1]}}, raw_r});

  // blend is rewritten as fresh + a*(old - fresh), rounded at bit 16
  always_comb begin
    case (state_r)
      ST_MUL_A: begin
        mul_a = $signed({1'b0, alpha_alt_r});
        mul_b = alt_d - x_d;
      end
      ST_MUL_K: begin
        mul_a = SPEED_SCALE;
        mul_b = alt_new_d - alt_d;
      end
      ST_MUL_S: begin
        mul_a = $signed({1'b0, alpha_spd_r});
        mul_b = spd_d - raw_d;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // round-half-up then floor shift
  logic signed [PW-1:0] rnd_sum, rnd_sh;
  logic signed [BW-1:0] blend_q, x_b, raw_b, alt_blend, spd_blend;

  assign rnd_sum     = prod_r + $signed(HALF_LSB);
  assign rnd_sh      = rnd_sum >>> Q_FRAC;
  assign blend_q     = rnd_sh[BW-1:0];
  assign x_b         = $signed({{(BW-AW){x_r[AW-1]}}, x_r});
  assign raw_b       = $signed({{(BW-SW){raw_r[SW-1]}}, raw_r});
  assign alt_blend   = x_b + blend_q;
  assign spd_blend   = raw_b + blend_q;
  assign alt_new_nxt = alt_blend[AW-1:0];
  assign spd_new_nxt = spd_blend[SW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_ALT) alt_new_r <= alt_new_nxt;
    if (state_r == ST_SPD) spd_new_r <= spd_new_nxt;
  end

  // ---------------------------------------------------------------------------
  // Speed divide: |1000*dA| / t, sign restored afterwards
  // ---------------------------------------------------------------------------
  logic [PW-1:0] prod_mag;
  logic [NW-1:0] quotient;

  assign prod_mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);

  always_ff @(posedge clk) begin
    if (div_start) neg_r <= prod_r[PW-1];
  end

  afed_div #(
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag[NW-1:0]),
    .divisor  (t_r),
    .quotient (quotient),
    .done     (div_done)
  );

  // saturate to the speed range (truncation toward zero already holds)
  logic [QW-1:0] q_ext, q_neg;

  assign q_ext = QW'(quotient);
  assign q_neg = '0 - q_ext;

  always_comb begin
    if (!neg_r) raw_nxt = (q_ext > SPD_MAX_MAG) ? SPD_MAX : q_ext[SW-1:0];
    else        raw_nxt = (q_ext > SPD_MIN_MAG) ? SPD_MIN : q_neg[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SAT) raw_r <= raw_nxt;
  end

  // ---------------------------------------------------------------------------
  // Event test, confirm counter, peaks
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] alt_c, spd_c, launch_c, apogee_c, chute_c;
  logic [CW-1:0]        spd_mag;
  logic                 tested, cond;
  logic [COUNT_W-1:0]   cnt_inc;

  assign alt_c    = $signed({{(CW-AW){alt_new_r[AW-1]}}, alt_new_r});
  assign spd_c    = $signed({{(CW-SW){spd_new_r[SW-1]}}, spd_new_r});
  assign launch_c = $signed({{(CW-ALT_THR_W){launch_thr_r[ALT_THR_W-1]}}, launch_thr_r});
  assign apogee_c = $signed({{(CW-SPD_THR_W){apogee_thr_r[SPD_THR_W-1]}}, apogee_thr_r});
  assign chute_c  = $signed({{(CW-ALT_THR_W){chute_alt_r[ALT_THR_W-1]}}, chute_alt_r});
  assign spd_mag  = spd_c[CW-1] ? CW'(-spd_c) : CW'(spd_c);

  always_comb begin
    tested = 1'b1;
    cond   = 1'b0;
    case (mode_r)
      MODE_LAUNCH: cond = alt_c > launch_c;
      MODE_APOGEE: cond = spd_c < apogee_c;
      MODE_CHUTE:  cond = alt_c < chute_c;
      MODE_GROUND: cond = spd_mag < CW'(ground_thr_r);
      default:     tested = 1'b0;  // no event selected: counter untouched
    endcase
  end

  // counter sticks at its top value
  assign cnt_inc = (cnt_r == {COUNT_W{1'b1}}) ? cnt_r : cnt_r + COUNT_W'(1);
  assign fire    = tested && cond && (cnt_inc > margin_r);

  always_comb begin
    if (!tested)                 cnt_nxt = cnt_r;
    else if (!cond || fire)      cnt_nxt = '0;
    else                         cnt_nxt = cnt_inc;
  end

  assign pk_alt_nxt = (alt_new_r > pk_alt_r) ? alt_new_r : pk_alt_r;
  assign pk_spd_nxt = (spd_new_r > pk_spd_r) ? spd_new_r : pk_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r    <= '0;
      spd_r    <= '0;
      pk_alt_r <= '0;
      pk_spd_r <= '0;
      cnt_r    <= '0;
    end else if (evt_go) begin
      alt_r    <= alt_new_r;
      spd_r    <= spd_new_r;
      pk_alt_r <= pk_alt_nxt;
      pk_spd_r <= pk_spd_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] o_alt_r, o_pk_alt_r;
  logic signed [SW-1:0] o_spd_r, o_pk_spd_r;
  logic                 o_fired_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                         out_valid_r <= 1'b0;
    else if (evt_go)                    out_valid_r <= 1'b1;
    else if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (evt_go) begin
      o_alt_r    <= alt_new_r;
      o_spd_r    <= spd_new_r;
      o_pk_alt_r <= pk_alt_nxt;
      o_pk_spd_r <= pk_spd_nxt;
      o_fired_r  <= fire;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.filtered_altitude = o_alt_r;
  assign out_if.filtered_speed    = o_spd_r;
  assign out_if.peak_altitude     = o_pk_alt_r;
  assign out_if.peak_speed        = o_pk_spd_r;
  assign out_if.event_fired       = o_fired_r;

endmodule

`default_nettype wire

/* rtl/afed_checker.sv */
`default_nettype none

`include "altimeter_flight_event_detector_macros.svh"

module afed_checker #(
  parameter int AW = 24,
  parameter int SW = 20
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [AW-1:0] filtered_altitude,
  input logic signed [SW-1:0] filtered_speed,
  input logic signed [AW-1:0] peak_altitude,
  input logic signed [SW-1:0] peak_speed,
  input logic                 event_fired
);

  // one word in flight: busy right after an accept
  `AFED_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // stalled result holds
  `AFED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_altitude) && $stable(filtered_speed) && $stable(event_fired))

  // peaks never trail the values they track
  `AFED_ASSERT_NOW(a_peak_alt, out_valid, peak_altitude >= filtered_altitude)
  `AFED_ASSERT_NOW(a_peak_spd, out_valid, peak_speed >= filtered_speed)

endmodule

bind altimeter_flight_event_detector afed_checker #(
  .AW (ALTITUDE_BITS),
  .SW (SPEED_BITS)
) u_afed_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .filtered_altitude (out_if.filtered_altitude),
  .filtered_speed    (out_if.filtered_speed),
  .peak_altitude     (out_if.peak_altitude),
  .peak_speed        (out_if.peak_speed),
  .event_fired       (out_if.event_fired)
);

`default_nettype wire
